[sv/dense_layer_forward_mac_core_assert.svh]
// Assertion macros for the dense layer MAC core.
// Each use expects clk and arst_n in scope.
`ifndef DENSE_LAYER_FORWARD_MAC_CORE_ASSERT_SVH
`define DENSE_LAYER_FORWARD_MAC_CORE_ASSERT_SVH

// Same-cycle implication check.
`define DLFMAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define DLFMAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dlfmac_pkg.sv]
`default_nettype none
package dlfmac_pkg;

	// Store sizes and index widths
	localparam int MAX_INPUTS     = 16;
	localparam int MAX_NEURONS    = 16;
	localparam int IDX_W          = 4;
	localparam int CNT_W          = 5;
	localparam int VALUE_BITS_DEF = 16;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	// Register map, selected by paddr[2]
	localparam logic REG_INPUT_COUNT  = 1'b0;
	localparam logic REG_NEURON_COUNT = 1'b1;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_ELEM   = 2'd2
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	// Map a count register onto 1..maximum
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] r,
			input logic [CNT_W-1:0] maximum);
		logic [CNT_W-1:0] c;
		if (r == '0) begin
			c = CNT_W'(1);
		end else if (r > maximum) begin
			c = maximum;
		end else begin
			c = r;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[sv/dense_layer_forward_mac_core.sv]
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready      operation, input_index, neuron_index,
//                                                    value, vector_end
// result    out        result_valid / result_ready  out_neuron, activation, clipped, run_end
// config    in         APB (psel, penable, pwrite)  paddr, pwdata -> prdata
//
// Weight, bias and plain element writes are accepted in idle, where item_ready stays high.
// An element marked vector_end starts a run over N neurons and I inputs: one shared
// multiplier and accumulator take one product a cycle from the weight memory read port
// while in ST_RUN, and after each neuron's inputs the pipeline drains and the result is packed.
// item_ready is low for the whole run; a stalled result holds the sequencer in packing.
// Reset clears control state and sets both counts to 16; stores are not cleared.
`default_nettype none
`include "dense_layer_forward_mac_core_assert.svh"
module dense_layer_forward_mac_core
	import dlfmac_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [PADDR_W-1:0]           paddr,
	input  wire logic [PDATA_W-1:0]           pwdata,
	output logic      [PDATA_W-1:0]           prdata,
	output logic                              pready,
	// items
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [1:0]                   operation,
	input  wire logic [IDX_W-1:0]             input_index,
	input  wire logic [IDX_W-1:0]             neuron_index,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic                         vector_end,
	// results
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic      [IDX_W-1:0]             out_neuron,
	output logic signed [VALUE_BITS-1:0]      activation,
	output logic                              clipped,
	output logic                              run_end
);

	localparam int ACC_W  = (2 * VALUE_BITS + 6 > 64) ? 64 : 2 * VALUE_BITS + 6;
	localparam int PROD_W = 2 * VALUE_BITS;
	localparam int W_DEPTH = MAX_INPUTS * MAX_NEURONS;
	localparam logic [CNT_W-1:0] MAX_IN_C = CNT_W'(MAX_INPUTS);
	localparam logic [CNT_W-1:0] MAX_NR_C = CNT_W'(MAX_NEURONS);

	// Configuration registers
	logic [CNT_W-1:0] input_count_q;
	logic [CNT_W-1:0] neuron_count_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q  <= MAX_IN_C;
			neuron_count_q <= MAX_NR_C;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_INPUT_COUNT) begin
				input_count_q <= pwdata[CNT_W-1:0];
			end else begin
				neuron_count_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			REG_INPUT_COUNT:  prdata = PDATA_W'(input_count_q);
			REG_NEURON_COUNT: prdata = PDATA_W'(neuron_count_q);
			default:          prdata = '0;
		endcase
	end

	// Effective sizes
	logic [CNT_W-1:0] n_in;
	logic [CNT_W-1:0] n_nr;

	assign n_in = clamp_count(input_count_q, MAX_IN_C);
	assign n_nr = clamp_count(neuron_count_q, MAX_NR_C);

	// Item transfer and store write enables
	logic item_xfer;
	logic in_ok;
	logic nr_ok;
	logic w_we;
	logic b_we;
	logic x_we;
	logic start;

	assign item_xfer = item_valid && item_ready;
	assign in_ok     = {1'b0, input_index} < n_in;
	assign nr_ok     = {1'b0, neuron_index} < n_nr;
	assign w_we      = item_xfer && (operation == OP_WEIGHT) && in_ok && nr_ok;
	assign b_we      = item_xfer && (operation == OP_BIAS) && nr_ok;
	assign x_we      = item_xfer && (operation == OP_ELEM) && in_ok;
	assign start     = item_xfer && (operation == OP_ELEM) && vector_end;

	// Sequencer
	state_t state_q;
	state_t state_d;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic             i_last;
	logic             j_last;
	logic             issue;
	logic             pack;
	logic             acc_rdy_q;
	logic             out_free;

	assign i_last   = ({1'b0, i_q} == n_in - CNT_W'(1));
	assign j_last   = ({1'b0, j_q} == n_nr - CNT_W'(1));
	assign out_free = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		issue      = 1'b0;
		pack       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (i_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (acc_rdy_q && out_free) begin
					pack    = 1'b1;
					state_d = j_last ? ST_IDLE : ST_RUN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the input and neuron counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (start) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (issue) begin
					i_q <= i_last ? '0 : i_q + IDX_W'(1);
				end
				if (pack) begin
					j_q <= j_last ? '0 : j_q + IDX_W'(1);
				end
			end
		end
	end

	// Stores with registered reads
	logic signed [VALUE_BITS-1:0] w_mem [W_DEPTH];
	logic signed [VALUE_BITS-1:0] b_mem [MAX_NEURONS];
	logic signed [VALUE_BITS-1:0] x_mem [MAX_INPUTS];
	logic signed [VALUE_BITS-1:0] w_rd_s1;
	logic signed [VALUE_BITS-1:0] b_rd_s1;
	logic signed [VALUE_BITS-1:0] x_rd_s1;

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[{input_index, neuron_index}] <= value;
		end
		w_rd_s1 <= w_mem[{i_q, j_q}];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[neuron_index] <= value;
		end
		b_rd_s1 <= b_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[input_index] <= value;
		end
		x_rd_s1 <= x_mem[i_q];
	end

	// Pipeline control tags
	logic vld_s1;
	logic first_s1;
	logic last_s1;
	logic vld_s2;
	logic first_s2;
	logic last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			vld_s1   <= issue;
			first_s1 <= issue && (i_q == '0);
			last_s1  <= issue && i_last;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// Shared multiplier
	logic signed [PROD_W-1:0]     prod_s2;
	logic signed [VALUE_BITS-1:0] bias_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= x_rd_s1 * w_rd_s1;
		bias_s2 <= b_rd_s1;
	end

	// Accumulate; the first product of a neuron starts from the shifted bias
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;

	assign acc_base = first_s2 ? (ACC_W'(bias_s2) <<< 8) : acc_q;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= acc_base + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_rdy_q <= 1'b0;
		end else if (vld_s2 && last_s2) begin
			acc_rdy_q <= 1'b1;
		end else if (pack) begin
			acc_rdy_q <= 1'b0;
		end
	end

	// Round half up, then saturate on the upper bits
	logic [ACC_W-1:0]          rnd;
	logic [ACC_W-VALUE_BITS-8:0] rnd_hi;
	logic                      sat;
	logic [VALUE_BITS-1:0]     res;

	assign rnd    = acc_q + ACC_W'(128);
	assign rnd_hi = rnd[ACC_W-1:VALUE_BITS+7];
	assign sat    = !((&rnd_hi) || !(|rnd_hi));
	always_comb begin
		if (!sat) begin
			res = rnd[VALUE_BITS+7:8];
		end else if (rnd[ACC_W-1]) begin
			res = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			res = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	end

	// Result register
	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_neuron_q;
	logic [VALUE_BITS-1:0] activation_q;
	logic                  clipped_q;
	logic                  run_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pack) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pack) begin
			out_neuron_q <= j_q;
			activation_q <= res;
			clipped_q    <= sat;
			run_end_q    <= j_last;
		end
	end

	assign result_valid = out_valid_q;
	assign out_neuron   = out_neuron_q;
	assign activation   = activation_q;
	assign clipped      = clipped_q;
	assign run_end      = run_end_q;

	// Checks
	`DLFMAC_ASSERT_NOW(a_idle_drained, item_ready, !vld_s1 && !vld_s2 && !acc_rdy_q, "idle with work in flight")
	`DLFMAC_ASSERT_NEXT(a_last_sets_rdy, vld_s2 && last_s2, acc_rdy_q, "last product did not finish the sum")
	`DLFMAC_ASSERT_NOW(a_rdy_alone, acc_rdy_q, !vld_s1 && !vld_s2, "products in flight after sum finished")
	`DLFMAC_ASSERT_NOW(a_first_clean, vld_s2 && first_s2, !acc_rdy_q, "new neuron started before packing")

endmodule
`default_nettype wire
